// ----- hdl/sasf_pkg.sv -----
// Shared types, constants and helpers for the sequence alignment score fill block.
package sasf_pkg;

    // Capacity of each symbol store.
    localparam int MAX_LEN  = 256;
    localparam int SYM_W    = 8;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int POS_W    = $clog2(MAX_LEN + 1);
    localparam int CFG_W    = 3;
    // Cell scores range from about -7*MAX_LEN up to 7*MAX_LEN.
    localparam int SCORE_W  = $clog2(14 * MAX_LEN + 8) + 1;
    localparam int BEST_W   = 11;
    localparam int BEST_MAX = (1 << BEST_W) - 1;

    // APB register map.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_MATCH_BONUS = 1'b0;
    localparam logic REG_GAP_COST    = 1'b1;

    // Command operation codes.
    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_COMPUTE     = 2'd2;

    typedef logic signed [SCORE_W-1:0] t_score;

    typedef struct packed {
        logic [1:0]       operation;
        logic [SYM_W-1:0] symbol;
    } t_cmd;

    typedef struct packed {
        logic [BEST_W-1:0] best_score;
        logic [POS_W-1:0]  best_row;
        logic [POS_W-1:0]  best_col;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] match_bonus;
        logic [CFG_W-1:0] gap_cost;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic             sel_second;
        logic [SYM_W-1:0] symbol;
    } t_seq_wr;

    typedef struct packed {
        logic             first_en;
        logic [IDX_W-1:0] first_addr;
        logic             second_en;
        logic [IDX_W-1:0] second_addr;
    } t_seq_rd;

    typedef struct packed {
        logic [SYM_W-1:0] first;
        logic [SYM_W-1:0] second;
    } t_seq_sym;

    typedef struct packed {
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] second;
    } t_seq_lens;

    // Clamp a non-negative score to the result field.
    function automatic logic [BEST_W-1:0] sat_best(input t_score score);
        logic signed [31:0] wide;
        wide = 32'(score);
        if (wide > 32'sd2047) begin
            return BEST_W'(BEST_MAX);
        end
        return wide[BEST_W-1:0];
    endfunction

endpackage

// ----- hdl/sequence_alignment_score_fill_core.sv -----
// Top level of the sequence alignment score fill block.
// Command interface: a command transfers on a clock edge where start is high
// and busy is low. Append commands (operation 0 for the first sequence, 1 for
// the second) leave busy low, so one symbol can be loaded every cycle while
// no compute is running; symbols past 256 per sequence are dropped, and
// operation code 3 does nothing. A compute command raises busy until the fill
// is done (no grid cells are filled if either loaded length is zero): the row
// buffer memory is read, updated and written back one grid cell per cycle,
// and each row begins with a step that fetches its first-sequence symbol. The
// result appears on o_result for exactly one cycle, flagged by o_res_valid,
// in the cycle busy falls; there is no backpressure, so the receiver must
// capture it then. Both lengths clear as the result is produced. Write the
// APB registers (match bonus at 0x0, gap cost at 0x4) only while busy is low.
module sequence_alignment_score_fill_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sasf_pkg::t_cmd              i_cmd,
    output logic                        o_res_valid,
    output sasf_pkg::t_result           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sasf_pkg::APB_AW-1:0] paddr,
    input  logic [sasf_pkg::APB_DW-1:0] pwdata,
    output logic [sasf_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import sasf_pkg::*;

    t_cfg      w_cfg;
    t_seq_wr   w_seq_wr;
    t_seq_rd   w_seq_rd;
    t_seq_sym  w_seq_sym;
    t_seq_lens w_lens;
    logic      w_accept;
    logic      w_go;
    logic      w_clear;
    logic      w_busy;

    // Decode the accepted command transfer.
    assign w_accept          = start && !w_busy;
    assign w_seq_wr.valid    = w_accept && (i_cmd.operation == OP_LOAD_FIRST ||
                                            i_cmd.operation == OP_LOAD_SECOND);
    assign w_seq_wr.sel_second = (i_cmd.operation == OP_LOAD_SECOND);
    assign w_seq_wr.symbol   = i_cmd.symbol;
    assign w_go              = w_accept && (i_cmd.operation == OP_COMPUTE);

    sasf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Symbol stores; lengths clear when the fill finishes.
    sasf_seq_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_seq_wr),
        .i_clear (w_clear),
        .i_rd    (w_seq_rd),
        .o_sym   (w_seq_sym),
        .o_lens  (w_lens)
    );

    // Walk the grid row by row, one cell per cycle within a row.
    sasf_fill_engine u_fill (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_cfg       (w_cfg),
        .i_lens      (w_lens),
        .i_sym       (w_seq_sym),
        .o_rd        (w_seq_rd),
        .o_clear     (w_clear),
        .o_busy      (w_busy),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    assign busy = w_busy;

endmodule

// ----- hdl/sasf_cfg_regs.sv -----
// APB configuration registers: match bonus and gap cost.
module sasf_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sasf_pkg::APB_AW-1:0] paddr,
    input  logic [sasf_pkg::APB_DW-1:0] pwdata,
    output logic [sasf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output sasf_pkg::t_cfg             o_cfg
);
    import sasf_pkg::*;

    logic [CFG_W-1:0] r_match_bonus;
    logic [CFG_W-1:0] r_gap_cost;
    logic             w_index;
    logic             w_wr;

    assign w_index = paddr[2];
    assign w_wr    = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_bonus <= CFG_W'(2);
            r_gap_cost    <= CFG_W'(1);
        end else if (w_wr) begin
            unique case (w_index)
                REG_MATCH_BONUS: r_match_bonus <= pwdata[CFG_W-1:0];
                REG_GAP_COST:    r_gap_cost    <= pwdata[CFG_W-1:0];
                default:         r_gap_cost    <= r_gap_cost;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_MATCH_BONUS: prdata = APB_DW'(r_match_bonus);
            REG_GAP_COST:    prdata = APB_DW'(r_gap_cost);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.match_bonus = r_match_bonus;
    assign o_cfg.gap_cost    = r_gap_cost;

endmodule

// ----- hdl/sasf_seq_store.sv -----
// Two symbol memories with their fill lengths.
module sasf_seq_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sasf_pkg::t_seq_wr   i_wr,
    input  logic                i_clear,
    input  sasf_pkg::t_seq_rd   i_rd,
    output sasf_pkg::t_seq_sym  o_sym,
    output sasf_pkg::t_seq_lens o_lens
);
    import sasf_pkg::*;

    logic [SYM_W-1:0] mem_first  [MAX_LEN];
    logic [SYM_W-1:0] mem_second [MAX_LEN];
    logic [POS_W-1:0] r_len_first;
    logic [POS_W-1:0] r_len_second;
    logic [SYM_W-1:0] r_sym_first;
    logic [SYM_W-1:0] r_sym_second;
    logic             w_wr_first;
    logic             w_wr_second;

    // Drop symbols once a store is full.
    assign w_wr_first  = i_wr.valid && !i_wr.sel_second && (r_len_first  < POS_W'(MAX_LEN));
    assign w_wr_second = i_wr.valid &&  i_wr.sel_second && (r_len_second < POS_W'(MAX_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_len_first  <= '0;
            r_len_second <= '0;
        end else begin
            if (w_wr_first) begin
                r_len_first <= r_len_first + 1'b1;
            end
            if (w_wr_second) begin
                r_len_second <= r_len_second + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_first) begin
            mem_first[r_len_first[IDX_W-1:0]] <= i_wr.symbol;
        end
        if (i_rd.first_en) begin
            r_sym_first <= mem_first[i_rd.first_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_second) begin
            mem_second[r_len_second[IDX_W-1:0]] <= i_wr.symbol;
        end
        if (i_rd.second_en) begin
            r_sym_second <= mem_second[i_rd.second_addr];
        end
    end

    assign o_sym.first   = r_sym_first;
    assign o_sym.second  = r_sym_second;
    assign o_lens.first  = r_len_first;
    assign o_lens.second = r_len_second;

endmodule

// ----- hdl/sasf_fill_engine.sv -----
// Grid fill sequencer: row buffer memory, cell datapath and best tracking.
module sasf_fill_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  sasf_pkg::t_cfg      i_cfg,
    input  sasf_pkg::t_seq_lens i_lens,
    input  sasf_pkg::t_seq_sym  i_sym,
    output sasf_pkg::t_seq_rd   o_rd,
    output logic                o_clear,
    output logic                o_busy,
    output logic                o_res_valid,
    output sasf_pkg::t_result   o_result
);
    import sasf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_COL,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             r_p_valid;
    logic [POS_W-1:0] r_p_row;
    logic [POS_W-1:0] r_p_col;
    t_score           r_up_q;
    t_score           r_diag;
    t_score           r_left;
    t_score           r_best;
    logic [POS_W-1:0] r_best_row;
    logic [POS_W-1:0] r_best_col;
    logic             r_res_valid;
    t_result          r_result;

    t_score           row_mem [MAX_LEN];

    logic [POS_W-1:0] w_row_m1;
    logic [POS_W-1:0] w_col_m1;
    logic [POS_W-1:0] w_pcol_m1;
    logic             w_first_row;
    logic             w_first_col;
    t_score           w_up;
    t_score           w_diag;
    t_score           w_left;
    t_score           w_max;
    t_score           w_cell;
    logic             w_take;

    assign w_row_m1  = r_row - 1'b1;
    assign w_col_m1  = r_col - 1'b1;
    assign w_pcol_m1 = r_p_col - 1'b1;

    assign o_rd.first_en    = (r_state == S_ROW);
    assign o_rd.first_addr  = w_row_m1[IDX_W-1:0];
    assign o_rd.second_en   = (r_state == S_COL);
    assign o_rd.second_addr = w_col_m1[IDX_W-1:0];

    // Row buffer: read the up value while the previous cell writes back.
    always_ff @(posedge i_clk) begin
        if (r_state == S_COL) begin
            r_up_q <= row_mem[w_col_m1[IDX_W-1:0]];
        end
        if (r_p_valid) begin
            row_mem[w_pcol_m1[IDX_W-1:0]] <= w_cell;
        end
    end

    // Cell datapath; row 0 and column 0 read as zero.
    always_comb begin
        w_first_row = (r_p_row == POS_W'(1));
        w_first_col = (r_p_col == POS_W'(1));
        w_up   = w_first_row ? '0 : r_up_q;
        w_diag = w_first_col ? '0 : r_diag;
        w_left = w_first_col ? '0 : r_left;
        w_max  = w_diag;
        if (w_left > w_max) begin
            w_max = w_left;
        end
        if (w_up > w_max) begin
            w_max = w_up;
        end
        if (i_sym.first == i_sym.second) begin
            w_cell = w_diag + signed'({{(SCORE_W-CFG_W){1'b0}}, i_cfg.match_bonus});
        end else begin
            w_cell = w_max - signed'({{(SCORE_W-CFG_W){1'b0}}, i_cfg.gap_cost});
        end
        w_take = r_p_valid && (w_cell >= r_best);
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_diag <= w_up;
            r_left <= w_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
            r_best      <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else begin
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
            if (w_take) begin
                r_best     <= w_cell;
                r_best_row <= r_p_row;
                r_best_col <= r_p_col;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_best     <= '0;
                        r_best_row <= '0;
                        r_best_col <= '0;
                        r_row      <= POS_W'(1);
                        if (i_lens.first == '0 || i_lens.second == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_ROW;
                        end
                    end
                end
                S_ROW: begin
                    r_col   <= POS_W'(1);
                    r_state <= S_COL;
                end
                S_COL: begin
                    r_p_valid <= 1'b1;
                    r_p_row   <= r_row;
                    r_p_col   <= r_col;
                    if (r_col == i_lens.second) begin
                        if (r_row == i_lens.first) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_res_valid         <= 1'b1;
                    r_result.best_score <= sat_best(r_best);
                    r_result.best_row   <= r_best_row;
                    r_result.best_col   <= r_best_col;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_clear     = (r_state == S_DONE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

// ----- hdl/sasf_checker.sv -----
// Port-level checks for the score fill core, bound to the top level.
module sasf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input sasf_pkg::t_cmd              i_cmd,
    input logic                        o_res_valid,
    input sasf_pkg::t_result           o_result,
    input logic                        pready
);
    import sasf_pkg::*;

    // A compute transfer always keeps the block busy in the next cycle.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.operation == OP_COMPUTE) |=> busy)
        else $error("compute transfer did not raise busy");

    // A result only follows a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(busy) && !busy))
        else $error("result without a preceding busy period");

    // One strobe per compute.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    // No cell reached means zero score at position 0,0.
    a_empty_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.best_row == '0) |->
            (o_result.best_col == '0 && o_result.best_score == '0))
        else $error("best position inconsistent with score");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind sequence_alignment_score_fill_core sasf_checker u_sasf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_res_valid (o_res_valid),
    .o_result    (o_result),
    .pready      (pready)
);
